// ----- hw/rtl/crc8lfr_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the frame receiver.
// No dependencies; every other file of the block depends on this package.
package crc8lfr_pkg;

  localparam int ByteW  = 8;
  localparam int IndexW = 3;

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_FLAGS = 2'd1;
  localparam logic [1:0] PH_LEN   = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CRC_ERR   = 2'd1;
  localparam logic [1:0] ST_TOO_SHORT = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  localparam logic [IndexW-1:0] REG_START_FLAG = 3'd0;
  localparam logic [IndexW-1:0] REG_CRC_POLY   = 3'd1;
  localparam logic [IndexW-1:0] REG_ACK_MASK   = 3'd2;
  localparam logic [IndexW-1:0] REG_MIN_LEN    = 3'd3;
  localparam logic [IndexW-1:0] REG_MAX_LEN    = 3'd4;

  localparam logic [ByteW-1:0] START_FLAG_RST = 8'd126;
  localparam logic [ByteW-1:0] CRC_POLY_RST   = 8'd7;
  localparam logic [ByteW-1:0] ACK_MASK_RST   = 8'd1;
  localparam logic [ByteW-1:0] MIN_LEN_RST    = 8'd4;
  localparam logic [ByteW-1:0] MAX_LEN_RST    = 8'd255;

  // Start flag, flags, length and CRC byte.
  localparam logic [ByteW-1:0] HDR_AND_CRC = 8'd4;

  typedef struct packed {
    logic [ByteW-1:0] start_flag;
    logic [ByteW-1:0] crc_poly;
    logic [ByteW-1:0] ack_mask;
    logic [ByteW-1:0] min_frame_len;
    logic [ByteW-1:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             frame_end;
    logic [1:0]       status;
    logic [ByteW-1:0] frame_type;
    logic [ByteW-1:0] frame_length;
    logic             is_ack;
  } result_t;

  // MSB-first CRC-8 over one byte, no reflection and no final xor.
  function automatic logic [ByteW-1:0] crc8_feed(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b,
                                                 input logic [ByteW-1:0] poly);
    logic [ByteW-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      v = v[ByteW-1] ? ({v[ByteW-2:0], 1'b0} ^ poly) : {v[ByteW-2:0], 1'b0};
    end
    return v;
  endfunction

endpackage

// ----- hw/rtl/crc8lfr_if.sv -----
// Handshake interfaces of the frame receiver: byte input, result output
// and register writes. Depends on crc8lfr_pkg for widths.
interface crc8lfr_byte_if;
  logic                        valid;
  logic                        ready;
  logic [crc8lfr_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crc8lfr_res_if;
  logic                        valid;
  logic                        ready;
  logic [crc8lfr_pkg::ByteW-1:0] payload_byte;
  logic                        frame_end;
  logic [1:0]                  status;
  logic [crc8lfr_pkg::ByteW-1:0] frame_type;
  logic [crc8lfr_pkg::ByteW-1:0] frame_length;
  logic                        is_ack;

  modport source (output valid, output payload_byte, output frame_end, output status,
                  output frame_type, output frame_length, output is_ack, input ready);
  modport sink (input valid, input payload_byte, input frame_end, input status,
                input frame_type, input frame_length, input is_ack, output ready);
endinterface

interface crc8lfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [crc8lfr_pkg::IndexW-1:0] index;
  logic [crc8lfr_pkg::ByteW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/crc8_length_frame_receiver_top.sv -----
// Top level of the length-prefixed CRC-8 frame receiver: register file and
// channel wiring. Depends on crc8lfr_pkg, crc8lfr_if and crc8lfr_deframer.
//
// The rx channel takes one link byte per word. Bytes are discarded until the
// start flag is seen; then the flags byte and total-length byte are read, and
// each body byte before the closing CRC byte leaves on the frame channel as a
// payload word. The last byte of a frame yields an end-of-frame word with the
// status, flags, length and acknowledge bit. A length outside the configured
// bounds, or under four bytes, gives an end-of-frame word at once and the
// receiver hunts again. The cfg channel writes the five registers by index
// and is always ready; writes beyond the register list are ignored.
// Registers should be written only while no frame is in progress.
// One byte is accepted every cycle while the frame channel is not stalling;
// a result word is presented once its byte, waiting in the input register,
// has passed the combinational CRC and phase logic into the result register. When the
// frame channel stalls with a word waiting, at most one byte more is taken
// into the input register and then rx drops ready.
// Reset returns the registers to their defaults, clears both pipeline
// stages and restarts the hunt for a start flag.
module crc8_length_frame_receiver_top (
  input logic           clk,
  input logic           rst,
  crc8lfr_byte_if.sink  rx,
  crc8lfr_res_if.source frame,
  crc8lfr_cfg_if.sink   cfg
);
  import crc8lfr_pkg::*;

  cfg_t    regs;
  result_t res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_flag    <= START_FLAG_RST;
      regs.crc_poly      <= CRC_POLY_RST;
      regs.ack_mask      <= ACK_MASK_RST;
      regs.min_frame_len <= MIN_LEN_RST;
      regs.max_frame_len <= MAX_LEN_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_START_FLAG: regs.start_flag    <= cfg.data;
        REG_CRC_POLY:   regs.crc_poly      <= cfg.data;
        REG_ACK_MASK:   regs.ack_mask      <= cfg.data;
        REG_MIN_LEN:    regs.min_frame_len <= cfg.data;
        REG_MAX_LEN:    regs.max_frame_len <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  crc8lfr_deframer u_deframer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .in_byte   (rx.rx_byte),
    .cfg       (regs),
    .res_valid (frame.valid),
    .res_ready (frame.ready),
    .res       (res)
  );

  assign frame.payload_byte = res.payload_byte;
  assign frame.frame_end    = res.frame_end;
  assign frame.status       = res.status;
  assign frame.frame_type   = res.frame_type;
  assign frame.frame_length = res.frame_length;
  assign frame.is_ack       = res.is_ack;

endmodule

// ----- hw/rtl/crc8lfr_deframer.sv -----
// Frame parser: input register, phase logic with the CRC-8 update, and the
// result register. Depends on crc8lfr_pkg for types, codes and crc8_feed.
module crc8lfr_deframer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [crc8lfr_pkg::ByteW-1:0]          in_byte,
  input  crc8lfr_pkg::cfg_t                      cfg,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output crc8lfr_pkg::result_t                   res
);
  import crc8lfr_pkg::*;

  logic             byte_valid;
  logic [ByteW-1:0] byte_q;
  logic             advance;

  logic [1:0]       phase, phase_next;
  logic [ByteW-1:0] byte_count, byte_count_next;
  logic [ByteW-1:0] running_crc, running_crc_next;
  logic [ByteW-1:0] flags_seen, flags_seen_next;
  logic [ByteW-1:0] length_seen, length_seen_next;
  logic [ByteW-1:0] crc_upd;
  logic             emit;
  result_t          res_next;

  assign advance  = !res_valid || res_ready;
  assign in_ready = !byte_valid || advance;
  assign crc_upd  = crc8_feed(running_crc, byte_q, cfg.crc_poly);

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    flags_seen_next  = flags_seen;
    length_seen_next = length_seen;
    emit             = 1'b0;
    res_next         = '0;
    res_next.frame_type   = flags_seen;
    res_next.frame_length = length_seen;
    res_next.is_ack       = |(flags_seen & cfg.ack_mask);
    case (phase)
      PH_HUNT: begin
        if (byte_q == cfg.start_flag) begin
          running_crc_next = crc8_feed('0, byte_q, cfg.crc_poly);
          byte_count_next  = 8'd1;
          phase_next       = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        flags_seen_next  = byte_q;
        running_crc_next = crc_upd;
        byte_count_next  = 8'd2;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        length_seen_next      = byte_q;
        running_crc_next      = crc_upd;
        byte_count_next       = 8'd3;
        res_next.frame_end    = 1'b1;
        res_next.frame_length = byte_q;
        if (byte_q < cfg.min_frame_len || byte_q < HDR_AND_CRC) begin
          emit            = 1'b1;
          res_next.status = ST_TOO_SHORT;
          phase_next      = PH_HUNT;
        end else if (byte_q > cfg.max_frame_len) begin
          emit            = 1'b1;
          res_next.status = ST_TOO_LONG;
          phase_next      = PH_HUNT;
        end else begin
          phase_next = PH_BODY;
        end
      end
      default: begin
        running_crc_next = crc_upd;
        byte_count_next  = byte_count + 8'd1;
        emit             = 1'b1;
        if (byte_count_next >= length_seen) begin
          res_next.frame_end = 1'b1;
          res_next.status    = (crc_upd == '0) ? ST_OK : ST_CRC_ERR;
          phase_next         = PH_HUNT;
        end else begin
          res_next              = '0;
          res_next.payload_byte = byte_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid  <= 1'b0;
      res_valid   <= 1'b0;
      phase       <= PH_HUNT;
      byte_count  <= '0;
      running_crc <= '0;
      flags_seen  <= '0;
      length_seen <= '0;
    end else begin
      if (in_ready) begin
        byte_valid <= in_valid;
      end
      if (advance) begin
        res_valid <= byte_valid && emit;
      end
      if (byte_valid && advance) begin
        phase       <= phase_next;
        byte_count  <= byte_count_next;
        running_crc <= running_crc_next;
        flags_seen  <= flags_seen_next;
        length_seen <= length_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= in_byte;
    end
    if (advance && byte_valid && emit) begin
      res <= res_next;
    end
  end

endmodule

// ----- tb/sv/crc8_length_frame_receiver_top_test.sv -----
// Self-checking test of the CRC-8 length-prefixed frame receiver: link bytes in,
// payload and end-of-frame words out, compared against a predictor of its own.
// Depends on crc8lfr_pkg, the crc8lfr interfaces and crc8_length_frame_receiver_top.
module crc8_length_frame_receiver_top_test;
  import crc8lfr_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crc8lfr_byte_if rx_if ();
  crc8lfr_res_if  frame_if ();
  crc8lfr_cfg_if  cfg_if ();

  crc8_length_frame_receiver_top DUT (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_if),
    .frame (frame_if),
    .cfg   (cfg_if)
  );

  always #1 clk = ~clk;

  logic [ByteW-1:0] link_bytes[$];
  result_t          frame_words_due[$];

  cfg_t             rx_cfg;
  cfg_t             plan_cfg;
  logic [1:0]       rx_phase;
  logic [ByteW-1:0] rx_count;
  logic [ByteW-1:0] rx_crc;
  logic [ByteW-1:0] rx_flags;
  logic [ByteW-1:0] rx_len;
  result_t          got_word;
  result_t          want_word;

  int errors        = 0;
  int bytes_taken   = 0;
  int bytes_queued  = 0;
  int payload_words = 0;
  int settings_used = 1;
  int idle_cycles   = 0;
  int status_seen[4];
  bit rx_took       = 1'b0;
  int burst_left    = 0;
  int gap_left      = 0;
  int stall_cycle   = 0;
  int stall_mode    = 0;

  function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b,
                                                 input logic [ByteW-1:0] poly);
    logic [ByteW-1:0] r;
    logic             fb;
    r = crc;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = r[ByteW-1] ^ b[i];
      r  = r << 1;
      if (fb) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  function automatic result_t end_report(input logic [1:0] st);
    result_t w;
    w              = '0;
    w.frame_end    = 1'b1;
    w.status       = st;
    w.frame_type   = rx_flags;
    w.frame_length = rx_len;
    w.is_ack       = |(rx_flags & rx_cfg.ack_mask);
    return w;
  endfunction

  task automatic deframe_byte(input logic [ByteW-1:0] b);
    result_t w;
    w = '0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == rx_cfg.start_flag) begin
          rx_crc   = crc8_step('0, b, rx_cfg.crc_poly);
          rx_count = 8'd1;
          rx_phase = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        rx_flags = b;
        rx_crc   = crc8_step(rx_crc, b, rx_cfg.crc_poly);
        rx_count = 8'd2;
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        rx_len   = b;
        rx_crc   = crc8_step(rx_crc, b, rx_cfg.crc_poly);
        rx_count = 8'd3;
        if (b < rx_cfg.min_frame_len || b < HDR_AND_CRC) begin
          frame_words_due.push_back(end_report(ST_TOO_SHORT));
          rx_phase = PH_HUNT;
        end else if (b > rx_cfg.max_frame_len) begin
          frame_words_due.push_back(end_report(ST_TOO_LONG));
          rx_phase = PH_HUNT;
        end else begin
          rx_phase = PH_BODY;
        end
      end
      default: begin
        rx_crc   = crc8_step(rx_crc, b, rx_cfg.crc_poly);
        rx_count = rx_count + 8'd1;
        if (rx_count >= rx_len) begin
          frame_words_due.push_back(end_report((rx_crc == '0) ? ST_OK : ST_CRC_ERR));
          rx_phase = PH_HUNT;
        end else begin
          w.payload_byte = b;
          frame_words_due.push_back(w);
        end
      end
    endcase
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_cfg   = '{START_FLAG_RST, CRC_POLY_RST, ACK_MASK_RST, MIN_LEN_RST, MAX_LEN_RST};
      rx_phase = PH_HUNT;
      rx_count = '0;
      rx_crc   = '0;
      rx_flags = '0;
      rx_len   = '0;
      rx_took  = 1'b0;
    end else begin
      idle_cycles++;
      rx_took = rx_if.valid && rx_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        idle_cycles = 0;
        case (cfg_if.index)
          REG_START_FLAG: rx_cfg.start_flag    = cfg_if.data;
          REG_CRC_POLY:   rx_cfg.crc_poly      = cfg_if.data;
          REG_ACK_MASK:   rx_cfg.ack_mask      = cfg_if.data;
          REG_MIN_LEN:    rx_cfg.min_frame_len = cfg_if.data;
          REG_MAX_LEN:    rx_cfg.max_frame_len = cfg_if.data;
          default: ;
        endcase
      end
      if (rx_took) begin
        idle_cycles = 0;
        deframe_byte(rx_if.rx_byte);
        void'(link_bytes.pop_front());
        bytes_taken++;
      end
      if (frame_if.valid && frame_if.ready) begin
        idle_cycles = 0;
        got_word = '{payload_byte: frame_if.payload_byte, frame_end: frame_if.frame_end,
                     status: frame_if.status, frame_type: frame_if.frame_type,
                     frame_length: frame_if.frame_length, is_ack: frame_if.is_ack};
        if (frame_words_due.size() == 0) begin
          $display("%0t: unexpected frame word, expected none, got %p", $time, got_word);
          errors++;
        end else begin
          want_word = frame_words_due.pop_front();
          check_field("payload_byte", want_word.payload_byte, got_word.payload_byte);
          check_field("frame_end", want_word.frame_end, got_word.frame_end);
          check_field("status", want_word.status, got_word.status);
          check_field("frame_type", want_word.frame_type, got_word.frame_type);
          check_field("frame_length", want_word.frame_length, got_word.frame_length);
          check_field("is_ack", want_word.is_ack, got_word.is_ack);
        end
        if (got_word.frame_end) begin
          status_seen[got_word.status]++;
        end else begin
          payload_words++;
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog, no word moved for %0d cycles, %0d words still due",
                 $time, idle_cycles, frame_words_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // The sender runs in bursts; a word already offered is held until taken.
  always @(negedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_took) begin
      if (gap_left > 0) begin
        rx_if.valid <= 1'b0;
        gap_left--;
      end else if (link_bytes.size() > 0) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= link_bytes[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    stall_cycle++;
    if (stall_cycle % 64 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0:       frame_if.ready <= 1'b1;
      1:       frame_if.ready <= (stall_cycle % 4) != 3;
      2:       frame_if.ready <= $urandom_range(0, 2) != 0;
      default: frame_if.ready <= stall_cycle[2];
    endcase
  end

  task automatic push_byte(input logic [ByteW-1:0] b);
    link_bytes.push_back(b);
    bytes_queued++;
  endtask

  // A length outside the bounds sends the header only, since the receiver
  // hunts again straight after the length byte.
  task automatic send_frame(input logic [ByteW-1:0] flags, input logic [ByteW-1:0] len,
                            input bit corrupt, input int keep, input int fill);
    logic [ByteW-1:0] crc;
    logic [ByteW-1:0] b;
    int               n;
    n = (len >= HDR_AND_CRC && len >= plan_cfg.min_frame_len &&
         len <= plan_cfg.max_frame_len) ? int'(len) : 3;
    if (keep > 0 && keep < n) begin
      n = keep;
    end
    crc = '0;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        b = plan_cfg.start_flag;
      end else if (i == 1) begin
        b = flags;
      end else if (i == 2) begin
        b = len;
      end else if (i == int'(len) - 1) begin
        b = corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc;
      end else begin
        b = (fill < 0) ? 8'($urandom) : 8'(fill);
      end
      push_byte(b);
      crc = crc8_step(crc, b, plan_cfg.crc_poly);
    end
  endtask

  task automatic run_traffic(input int n_bytes);
    int target;
    int sel;
    int lo;
    int hi;
    int len;
    target = bytes_queued + n_bytes;
    lo = (plan_cfg.min_frame_len > HDR_AND_CRC) ? int'(plan_cfg.min_frame_len)
                                                : int'(HDR_AND_CRC);
    hi = plan_cfg.max_frame_len;
    while (bytes_queued < target) begin
      sel = $urandom_range(0, 99);
      if (sel >= 88) begin
        repeat ($urandom_range(1, 4)) link_bytes.push_back(8'($urandom));
      end else if (sel >= 78 || lo > hi) begin
        if (hi < 255 && $urandom_range(0, 1) == 1) begin
          len = $urandom_range(hi + 1, 255);
        end else begin
          len = $urandom_range(0, lo - 1);
        end
        send_frame(8'($urandom), 8'(len), 1'b0, 0, -1);
      end else begin
        if ($urandom_range(0, 15) == 0) begin
          len = $urandom_range(lo, hi);
        end else begin
          len = $urandom_range(lo, (hi < lo + 10) ? hi : lo + 10);
        end
        send_frame(8'($urandom), 8'(len), sel >= 60 && sel < 70,
                   (sel >= 70) ? $urandom_range(1, len - 1) : 0, -1);
      end
    end
  endtask

  task automatic wait_drained();
    while (link_bytes.size() != 0 || frame_words_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Registers may only change between frames, so a cut-off frame is run out
  // with filler bytes before the pipeline is left to empty.
  task automatic settle();
    wait_drained();
    while (rx_phase != PH_HUNT) begin
      link_bytes.push_back('0);
      wait_drained();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [ByteW-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_START_FLAG: plan_cfg.start_flag    = val;
      REG_CRC_POLY:   plan_cfg.crc_poly      = val;
      REG_ACK_MASK:   plan_cfg.ack_mask      = val;
      REG_MIN_LEN:    plan_cfg.min_frame_len = val;
      REG_MAX_LEN:    plan_cfg.max_frame_len = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [ByteW-1:0] sflag, input logic [ByteW-1:0] poly,
                                input logic [ByteW-1:0] mask, input logic [ByteW-1:0] min_len,
                                input logic [ByteW-1:0] max_len, input bit junk);
    write_reg(REG_START_FLAG, sflag);
    write_reg(REG_CRC_POLY, poly);
    write_reg(REG_ACK_MASK, mask);
    write_reg(REG_MIN_LEN, min_len);
    write_reg(REG_MAX_LEN, max_len);
    if (junk) begin
      for (int k = int'(REG_MAX_LEN) + 1; k < 2 ** IndexW; k++) begin
        write_reg(k[IndexW-1:0], 8'($urandom));
      end
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_settings();
    int min_len;
    int max_len;
    min_len = $urandom_range(4, 12);
    max_len = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(min_len, 40);
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'(min_len), 8'(max_len),
                   $urandom_range(0, 1) == 1);
  endtask

  initial begin
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    frame_if.ready = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    plan_cfg = '{START_FLAG_RST, CRC_POLY_RST, ACK_MASK_RST, MIN_LEN_RST, MAX_LEN_RST};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    send_frame(8'hFF, 8'd4, 1'b0, 0, -1);
    send_frame(8'h01, 8'd6, 1'b0, 0, START_FLAG_RST);
    send_frame(8'h00, 8'd5, 1'b0, 0, 8'hFF);
    send_frame(8'h02, 8'd4, 1'b1, 0, -1);
    send_frame(8'hFE, 8'd0, 1'b0, 0, -1);
    send_frame(8'h01, 8'd3, 1'b0, 0, -1);
    run_traffic(60);
    settle();

    apply_settings(8'h00, 8'hFF, 8'hFF, 8'd4, 8'd4, 1'b1);
    run_traffic(50);
    settle();

    apply_settings(8'hFF, 8'h00, 8'h80, 8'd255, 8'd255, 1'b0);
    run_traffic(40);
    settle();

    // Minimum above maximum: no length passes both bounds.
    apply_settings(8'h55, 8'h31, 8'h00, 8'd20, 8'd10, 1'b0);
    run_traffic(40);
    settle();

    repeat (3) begin
      random_settings();
      run_traffic(50);
      settle();
    end

    $display("Covered %0d link bytes under %0d register settings, giving %0d payload words.",
             bytes_taken, settings_used, payload_words);
    $display("Frame reports seen: ok %0d, crc error %0d, too short %0d, too long %0d.",
             status_seen[ST_OK], status_seen[ST_CRC_ERR], status_seen[ST_TOO_SHORT],
             status_seen[ST_TOO_LONG]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
